@@ rtl/ftc_pkg.sv @@
package ftc_pkg;

   // accumulator holds a remainder below the period plus one step
   localparam int unsigned ACC_WIDTH    = 33;
   localparam int unsigned PERIOD_WIDTH = 32;

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 32'd16000;

   localparam int unsigned SEC_WIDTH  = 6;
   localparam int unsigned MIN_WIDTH  = 6;
   localparam int unsigned HOUR_WIDTH = 5;
   localparam int unsigned DAYS_OUT_WIDTH = 16;

   localparam logic [SEC_WIDTH-1:0]  SEC_LAST  = 6'd59;
   localparam logic [MIN_WIDTH-1:0]  MIN_LAST  = 6'd59;
   localparam logic [HOUR_WIDTH-1:0] HOUR_LAST = 5'd23;

   typedef struct packed {
      logic                  half;
      logic [SEC_WIDTH-1:0]  sec;
      logic [MIN_WIDTH-1:0]  min;
      logic [HOUR_WIDTH-1:0] hour;
   } tod_type;

endpackage

@@ rtl/fractional_tick_time_of_day_clock.sv @@
// channel | ports                          | direction | word
// --------+--------------------------------+-----------+---------------------------------
// req     | req_valid/req_ready, req_tick  | in        | one timer overflow (or none)
// rsp     | rsp_valid/rsp_ready, rsp_*     | out       | fire flag and time after the step
// csr     | csr_wr_en, csr_wr_data         | in        | period, timer clocks per half-second
//
// one word per cycle sustained while the result is taken: a word is held in the input stage,
// then the accumulator add/compare/subtract and the time cascade update state and load the
// result register as the word leaves it, so rsp_valid rises from the result register.
// reset is synchronous and active high: accumulator and time go to zero, period to 16000.
// a stalled result holds; the input stage still takes a word while the result waits,
// and req_ready drops only when both the input stage and the result register are full.
module fractional_tick_time_of_day_clock
   import ftc_pkg::*;
#(
   parameter int unsigned STEP_CLOCKS = 256,
   parameter int unsigned DAY_WIDTH   = 16
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_tick,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_fire,
   output logic                      rsp_half_second,
   output logic [SEC_WIDTH-1:0]      rsp_seconds,
   output logic [MIN_WIDTH-1:0]      rsp_minutes,
   output logic [HOUR_WIDTH-1:0]     rsp_hours,
   output logic [DAYS_OUT_WIDTH-1:0] rsp_days,

   input  logic                      csr_wr_en,
   input  logic [PERIOD_WIDTH-1:0]   csr_wr_data
);

   // step size as seen by the accumulator
   localparam logic [ACC_WIDTH-1:0] STEP_ACC = ACC_WIDTH'(STEP_CLOCKS);

   // period register
   logic [PERIOD_WIDTH-1:0] period_ff;

   // input stage
   logic s1_valid_ff;
   logic s1_tick_ff;

   // accumulator
   logic [ACC_WIDTH-1:0] acc_ff;
   logic [ACC_WIDTH-1:0] acc_in;
   logic [ACC_WIDTH-1:0] acc_sum;
   logic [ACC_WIDTH-1:0] eff_period;
   logic                 fire;

   // result register
   logic                      rsp_valid_ff;
   logic                      rsp_fire_ff;
   tod_type                   rsp_tod_ff;
   logic [DAYS_OUT_WIDTH-1:0] rsp_days_ff;

   // handshake
   logic advance;   // input stage word moves into the result register
   logic req_take;

   tod_type              tod_next;
   logic [DAY_WIDTH-1:0] day_next;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_tick_ff <= req_tick;
      end
   end

   // periods below one step are clamped to the step so the remainder stays bounded
   always_comb begin
      if (ACC_WIDTH'(period_ff) < STEP_ACC) begin
         eff_period = STEP_ACC;
      end else begin
         eff_period = ACC_WIDTH'(period_ff);
      end
   end

   // remainder is kept across events, so no error builds up
   assign acc_sum = acc_ff + STEP_ACC;
   assign fire    = s1_tick_ff && (acc_sum >= eff_period);

   always_comb begin
      if (fire) begin
         acc_in = acc_sum - eff_period;
      end else if (s1_tick_ff) begin
         acc_in = acc_sum;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (advance) begin
         acc_ff <= acc_in;
      end
   end

   // half-second / second / minute / hour / day cascade
   ftc_tod_counter #(
      .DAY_WIDTH (DAY_WIDTH)
   ) u_tod (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .advance  (fire),
      .tod_next (tod_next),
      .day_next (day_next)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_fire_ff <= fire;
         rsp_tod_ff  <= tod_next;
         rsp_days_ff <= DAYS_OUT_WIDTH'({{DAYS_OUT_WIDTH{1'b0}}, day_next});
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fire        = rsp_fire_ff;
   assign rsp_half_second = rsp_tod_ff.half;
   assign rsp_seconds     = rsp_tod_ff.sec;
   assign rsp_minutes     = rsp_tod_ff.min;
   assign rsp_hours       = rsp_tod_ff.hour;
   assign rsp_days        = rsp_days_ff;

endmodule

@@ rtl/ftc_tod_counter.sv @@
module ftc_tod_counter
   import ftc_pkg::*;
#(
   parameter int unsigned DAY_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 update,
   input  logic                 advance,
   output tod_type              tod_next,
   output logic [DAY_WIDTH-1:0] day_next
);

   tod_type              tod_ff;
   tod_type              tod_in;
   logic [DAY_WIDTH-1:0] day_ff;
   logic [DAY_WIDTH-1:0] day_in;

   logic half_wrap;
   logic sec_wrap;
   logic min_wrap;
   logic hour_wrap;

   // carry chain of the cascade
   assign half_wrap = advance && tod_ff.half;
   assign sec_wrap  = half_wrap && (tod_ff.sec == SEC_LAST);
   assign min_wrap  = sec_wrap && (tod_ff.min == MIN_LAST);
   assign hour_wrap = min_wrap && (tod_ff.hour == HOUR_LAST);

   always_comb begin
      tod_in = tod_ff;
      day_in = day_ff;
      if (advance) begin
         tod_in.half = ~tod_ff.half;
      end
      if (half_wrap) begin
         tod_in.sec = sec_wrap ? '0 : tod_ff.sec + SEC_WIDTH'(1);
      end
      if (sec_wrap) begin
         tod_in.min = min_wrap ? '0 : tod_ff.min + MIN_WIDTH'(1);
      end
      if (min_wrap) begin
         tod_in.hour = hour_wrap ? '0 : tod_ff.hour + HOUR_WIDTH'(1);
      end
      if (hour_wrap) begin
         day_in = day_ff + DAY_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tod_ff <= '0;
         day_ff <= '0;
      end else if (update) begin
         tod_ff <= tod_in;
         day_ff <= day_in;
      end
   end

   assign tod_next = tod_in;
   assign day_next = day_in;

endmodule
